/* rtl/core/sdgf2_pkg.sv */
`default_nettype none

package sdgf2_pkg;

  // Fixed field widths
  localparam int unsigned OPC_W       = 2;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 64;

  // Opcodes (carried on s_axis_tuser)
  localparam logic [OPC_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OPC_W-1:0] OP_MUL  = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ = 2'd2;

  // Bit stream accumulator
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned SKIP_W = 6;

  typedef struct packed {
    logic              init;
    logic              append;
    logic [CNT_W-1:0]  len;
    logic              skip;
    logic [SKIP_W-1:0] skip_bits;
    logic              emit;
  } stream_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/sparse_dense_cyclic_gf2_multiply_unit.sv */
`default_nettype none

// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tuser: opcode; tdata: index, sparse, dense words
// m_axis    out  tvalid/tready         tdata: result word; tuser: multiply done flag
//
// Reset: a clearing pass zeroes all three stores, one word per cycle,
// with s_axis_tready low. A load or no-op answers straight from idle; a read waits in ST_RDWAIT.
// A multiply clears the product store, then walks the bits of each live sparse word;
// each set bit streams the dense operand from its rotated start position, and
// for it each product word costs a dense append, a stream check and a product RMW.
// One output register: a new transaction is taken in idle once it is empty or drains that cycle.
module sparse_dense_cyclic_gf2_multiply_unit #(
  parameter int unsigned POLY_BITS  = 17669,
  parameter int unsigned WORD_COUNT = 277
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tuser: [1:0] opcode
  // tdata: [8:0] word_index, [72:9] sparse_word, [136:73] dense_word, rest zero
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  // tdata: [63:0] result_word
  // tuser: [0] done_res
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned NWORDS    = (POLY_BITS + 63) / 64;
  localparam int unsigned LAST_BITS = POLY_BITS - 64 * (NWORDS - 1);
  localparam logic [63:0] LAST_MASK = {64{1'b1}} >> (64 - LAST_BITS);
  localparam int unsigned PWORDS    = (WORD_COUNT < NWORDS) ? WORD_COUNT : NWORDS;
  localparam int unsigned MAXW      = (NWORDS > WORD_COUNT) ? NWORDS : WORD_COUNT;
  localparam int unsigned CW        = $clog2(MAXW + 1);
  localparam int unsigned AW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned PW        = ($clog2(POLY_BITS) > 7) ? $clog2(POLY_BITS) : 7;
  localparam int unsigned XW        = sdgf2_pkg::IDX_W + 2;

  // Sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;   // reset clearing pass
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDWAIT = 4'd2;   // product read data arriving
  localparam logic [3:0] ST_PCLR   = 4'd3;   // zero the product
  localparam logic [3:0] ST_SRD    = 4'd4;   // fetch sparse word
  localparam logic [3:0] ST_SLD    = 4'd5;   // latch sparse word
  localparam logic [3:0] ST_SCAN   = 4'd6;   // walk sparse bits
  localparam logic [3:0] ST_DRD    = 4'd7;   // fetch dense word or go emit
  localparam logic [3:0] ST_DAPP   = 4'd8;   // append dense chunk to stream
  localparam logic [3:0] ST_DSKIP  = 4'd9;   // drop leading bits of first word
  localparam logic [3:0] ST_PRD    = 4'd10;  // fetch product word
  localparam logic [3:0] ST_PWR    = 4'd11;  // xor stream word into product
  localparam logic [3:0] ST_FIN    = 4'd12;  // report multiply done

  // Input fields
  logic [sdgf2_pkg::OPC_W-1:0]  in_opc;
  logic [sdgf2_pkg::IDX_W-1:0]  in_idx;
  logic [63:0]                  in_sparse;
  logic [63:0]                  in_dense;
  logic                         in_ok;
  logic                         accept;

  assign in_opc    = s_axis_tuser;
  assign in_idx    = s_axis_tdata[8:0];
  assign in_sparse = s_axis_tdata[72:9];
  assign in_dense  = s_axis_tdata[136:73];
  assign in_ok     = (XW'(in_idx) < XW'(WORD_COUNT));

  // Sequencer registers
  logic [3:0]     state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [CW-1:0]  sw_q, sw_d;      // sparse word
  logic [CW-1:0]  k_q, k_d;        // product word
  logic [CW-1:0]  rd_q, rd_d;      // next dense word of the stream
  logic [5:0]     bit_q, bit_d;
  logic [63:0]    sbits_q, sbits_d;
  logic [5:0]     skip_q, skip_d;
  logic           first_q, first_d;
  logic           dval_q, dval_d;
  logic           dlast_q, dlast_d;
  logic           rval_q, rval_d;

  // Output register
  logic           out_valid_q;
  logic [63:0]    out_data_q;
  logic           out_done_q;
  logic           out_load;
  logic [63:0]    out_data_n;
  logic           out_done_n;

  // Stores
  logic [63:0]    sparse_mem [WORD_COUNT];
  logic [63:0]    dense_mem  [WORD_COUNT];
  logic [63:0]    prod_mem   [WORD_COUNT];
  logic [63:0]    sp_rdata_q, dn_rdata_q, pr_rdata_q;

  logic           op_we;
  logic [AW-1:0]  op_wa;
  logic [63:0]    sp_wd, dn_wd;
  logic           sp_re, dn_re, pr_re, pr_we;
  logic [AW-1:0]  sp_ra, dn_ra, pr_ra, pr_wa;
  logic [63:0]    pr_wd;

  // Stream unit
  sdgf2_pkg::stream_ctl_t  sctl;
  logic [63:0]             chunk;
  logic [63:0]             strm_word;
  logic                    strm_full;

  // Start of the dense stream for sparse bit p: (-p) mod POLY_BITS
  logic [PW-1:0]  p_w;
  logic [PW-1:0]  j0;

  assign p_w = PW'({sw_q, bit_q});
  assign j0  = (p_w == '0) ? '0 : (PW'(POLY_BITS) - p_w);

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    sw_d       = sw_q;
    k_d        = k_q;
    rd_d       = rd_q;
    bit_d      = bit_q;
    sbits_d    = sbits_q;
    skip_d     = skip_q;
    first_d    = first_q;
    dval_d     = dval_q;
    dlast_d    = dlast_q;
    rval_d     = rval_q;
    out_load   = 1'b0;
    out_data_n = '0;
    out_done_n = 1'b0;
    op_we      = 1'b0;
    op_wa      = clr_q;
    sp_wd      = '0;
    dn_wd      = '0;
    sp_re      = 1'b0;
    sp_ra      = AW'(sw_q);
    dn_re      = 1'b0;
    dn_ra      = AW'(rd_q);
    pr_re      = 1'b0;
    pr_ra      = AW'(k_q);
    pr_we      = 1'b0;
    pr_wa      = clr_q;
    pr_wd      = '0;
    sctl       = '0;
    chunk      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        op_we = 1'b1;
        pr_we = 1'b1;
        if (clr_q == AW'(WORD_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opc)
            sdgf2_pkg::OP_LOAD: begin
              op_we    = in_ok;
              op_wa    = AW'(in_idx);
              sp_wd    = in_sparse;
              dn_wd    = in_dense;
              out_load = 1'b1;
            end
            sdgf2_pkg::OP_MUL: begin
              clr_d   = '0;
              state_d = ST_PCLR;
            end
            sdgf2_pkg::OP_READ: begin
              pr_re   = in_ok;
              pr_ra   = AW'(in_idx);
              rval_d  = in_ok;
              state_d = ST_RDWAIT;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        out_load   = 1'b1;
        out_data_n = rval_q ? pr_rdata_q : '0;
        state_d    = ST_IDLE;
      end
      ST_PCLR: begin
        pr_we = 1'b1;
        if (clr_q == AW'(WORD_COUNT - 1)) begin
          sw_d    = '0;
          state_d = ST_SRD;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_SRD: begin
        sp_re   = 1'b1;
        state_d = ST_SLD;
      end
      ST_SLD: begin
        sbits_d = sp_rdata_q & ((sw_q == CW'(NWORDS - 1)) ? LAST_MASK : {64{1'b1}});
        bit_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sbits_q == '0) begin
          if (sw_q == CW'(PWORDS - 1)) begin
            state_d = ST_FIN;
          end else begin
            sw_d    = sw_q + 1'b1;
            state_d = ST_SRD;
          end
        end else begin
          sbits_d = sbits_q >> 1;
          bit_d   = bit_q + 1'b1;
          if (sbits_q[0]) begin
            // set bit: rotate the dense operand by its position
            rd_d      = CW'(j0 >> 6);
            skip_d    = j0[5:0];
            first_d   = 1'b1;
            k_d       = '0;
            sctl.init = 1'b1;
            state_d   = ST_DRD;
          end
        end
      end
      ST_DRD: begin
        if (strm_full) begin
          state_d = ST_PRD;
        end else begin
          dval_d  = (rd_q < CW'(WORD_COUNT));
          dlast_d = (rd_q == CW'(NWORDS - 1));
          dn_re   = (rd_q < CW'(WORD_COUNT));
          state_d = ST_DAPP;
        end
      end
      ST_DAPP: begin
        // words beyond the store read as zero; last live word is trimmed
        chunk       = dval_q ? (dn_rdata_q & (dlast_q ? LAST_MASK : {64{1'b1}})) : '0;
        sctl.append = 1'b1;
        sctl.len    = dlast_q ? sdgf2_pkg::CNT_W'(LAST_BITS) : sdgf2_pkg::CNT_W'(64);
        rd_d        = dlast_q ? '0 : (rd_q + 1'b1);
        state_d     = first_q ? ST_DSKIP : ST_DRD;
      end
      ST_DSKIP: begin
        sctl.skip      = 1'b1;
        sctl.skip_bits = skip_q;
        first_d        = 1'b0;
        state_d        = ST_DRD;
      end
      ST_PRD: begin
        pr_re   = 1'b1;
        state_d = ST_PWR;
      end
      ST_PWR: begin
        pr_we     = 1'b1;
        pr_wa     = AW'(k_q);
        pr_wd     = pr_rdata_q ^
                    (strm_word & ((k_q == CW'(NWORDS - 1)) ? LAST_MASK : {64{1'b1}}));
        sctl.emit = 1'b1;
        if (k_q == CW'(PWORDS - 1)) begin
          state_d = ST_SCAN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_DRD;
        end
      end
      ST_FIN: begin
        out_load   = 1'b1;
        out_done_n = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sw_q    <= '0;
      k_q     <= '0;
      rd_q    <= '0;
      bit_q   <= '0;
      sbits_q <= '0;
      skip_q  <= '0;
      first_q <= 1'b0;
      dval_q  <= 1'b0;
      dlast_q <= 1'b0;
      rval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sw_q    <= sw_d;
      k_q     <= k_d;
      rd_q    <= rd_d;
      bit_q   <= bit_d;
      sbits_q <= sbits_d;
      skip_q  <= skip_d;
      first_q <= first_d;
      dval_q  <= dval_d;
      dlast_q <= dlast_d;
      rval_q  <= rval_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_n;
      out_done_q <= out_done_n;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_done_q;

  // Operand stores share write address and enable
  always_ff @(posedge clk_i) begin
    if (op_we) begin
      sparse_mem[op_wa] <= sp_wd;
    end
    if (sp_re) begin
      sp_rdata_q <= sparse_mem[sp_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_we) begin
      dense_mem[op_wa] <= dn_wd;
    end
    if (dn_re) begin
      dn_rdata_q <= dense_mem[dn_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pr_we) begin
      prod_mem[pr_wa] <= pr_wd;
    end
    if (pr_re) begin
      pr_rdata_q <= prod_mem[pr_ra];
    end
  end

  sdgf2_stream u_stream (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sctl),
    .chunk_i (chunk),
    .word_o  (strm_word),
    .full_o  (strm_full)
  );

endmodule

`default_nettype wire

/* rtl/core/sdgf2_stream.sv */
`default_nettype none

// Bit stream accumulator: appends variable-length chunks above the held bits,
// drops bits from the bottom, and hands out 64 bits at a time.
module sdgf2_stream (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sdgf2_pkg::stream_ctl_t  ctl_i,
  input  logic [63:0]             chunk_i,   // bits above ctl_i.len are zero
  output logic [63:0]             word_o,
  output logic                    full_o
);

  logic [127:0]                   acc_q, acc_d;
  logic [sdgf2_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (ctl_i.init) begin
      acc_d = '0;
      cnt_d = '0;
    end else if (ctl_i.append) begin
      acc_d = acc_q | ({64'd0, chunk_i} << cnt_q);
      cnt_d = cnt_q + ctl_i.len;
    end else if (ctl_i.skip) begin
      acc_d = acc_q >> ctl_i.skip_bits;
      cnt_d = cnt_q - sdgf2_pkg::CNT_W'(ctl_i.skip_bits);
    end else if (ctl_i.emit) begin
      acc_d = {64'd0, acc_q[127:64]};
      cnt_d = cnt_q - sdgf2_pkg::CNT_W'(64);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign word_o = acc_q[63:0];
  assign full_o = cnt_q[sdgf2_pkg::CNT_W-1];

endmodule

`default_nettype wire

/* tb/tb_sparse_dense_cyclic_gf2_multiply_unit.sv */
`default_nettype none

module tb_sparse_dense_cyclic_gf2_multiply_unit;

  localparam int unsigned POLY_BITS    = 17669;
  localparam int unsigned WORD_COUNT   = 277;
  localparam int unsigned STORE_BITS   = 64 * WORD_COUNT;
  localparam int unsigned IDX_MAX      = (1 << sdgf2_pkg::IDX_W) - 1;
  // Opcode 3 is unused by the block: it must answer with an all-zero result.
  localparam logic [sdgf2_pkg::OPC_W-1:0] OP_NOP = 2'd3;
  // Cap on live sparse weight before a multiply; each set sparse bit costs
  // a pass over every product word inside the block.
  localparam int unsigned WEIGHT_CAP   = 10;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [sdgf2_pkg::WORD_W-1:0] word;
    logic                         done;
  } gf2_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [sdgf2_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [sdgf2_pkg::OPC_W-1:0]       s_axis_tuser  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [sdgf2_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]                        m_axis_tuser;

  always #6 clk_i = ~clk_i;

  sparse_dense_cyclic_gf2_multiply_unit #(
    .POLY_BITS (POLY_BITS),
    .WORD_COUNT(WORD_COUNT)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the three stores and the expected-result FIFO
  // ---------------------------------------------------------------------------
  logic [sdgf2_pkg::WORD_W-1:0] sparse_mem  [WORD_COUNT];
  logic [sdgf2_pkg::WORD_W-1:0] dense_mem   [WORD_COUNT];
  logic [sdgf2_pkg::WORD_W-1:0] product_mem [WORD_COUNT];

  gf2_result_t pending_results[$];
  int unsigned fail_count = 0;

  // Side-idling controls shared by sender and receiver.
  bit          gaps_on    = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  function automatic void clear_stores();
    for (int w = 0; w < WORD_COUNT; w++) begin
      sparse_mem[w]  = '0;
      dense_mem[w]   = '0;
      product_mem[w] = '0;
    end
  endfunction

  // Bits of word w that sit below the polynomial degree.
  function automatic logic [sdgf2_pkg::WORD_W-1:0] live_bits(int unsigned w);
    int unsigned base;
    int unsigned rem;
    base = w * 64;
    if (base >= POLY_BITS) return '0;
    rem = POLY_BITS - base;
    if (rem >= 64) return '1;
    return (64'd1 << rem) - 64'd1;
  endfunction

  function automatic int unsigned sparse_live_weight();
    int unsigned weight;
    weight = 0;
    for (int w = 0; w < WORD_COUNT; w++) begin
      weight += $countones(sparse_mem[w] & live_bits(w));
    end
    return weight;
  endfunction

  // Cyclic convolution: each live sparse bit p adds the dense operand
  // rotated left by p around the POLY_BITS-long ring.
  function automatic void convolve_stores();
    logic [STORE_BITS-1:0] sparse_flat;
    logic [STORE_BITS-1:0] dense_flat;
    logic [STORE_BITS-1:0] prod_flat;
    logic [POLY_BITS-1:0]  dense_vec;
    logic [POLY_BITS-1:0]  prod_vec;
    for (int w = 0; w < WORD_COUNT; w++) begin
      sparse_flat[w*64 +: 64] = sparse_mem[w];
      dense_flat[w*64 +: 64]  = dense_mem[w];
    end
    dense_vec = dense_flat[POLY_BITS-1:0];
    prod_vec  = '0;
    for (int p = 0; p < POLY_BITS; p++) begin
      if (sparse_flat[p]) begin
        prod_vec ^= (dense_vec << p) | (dense_vec >> (POLY_BITS - p));
      end
    end
    prod_flat = '0;
    prod_flat[POLY_BITS-1:0] = prod_vec;
    for (int w = 0; w < WORD_COUNT; w++) begin
      product_mem[w] = prod_flat[w*64 +: 64];
    end
  endfunction

  // Applies one accepted transaction to the shadow stores.
  function automatic gf2_result_t gf2_step(logic [sdgf2_pkg::OPC_W-1:0] op,
                                           logic [sdgf2_pkg::IDX_W-1:0] idx,
                                           logic [sdgf2_pkg::WORD_W-1:0] sp,
                                           logic [sdgf2_pkg::WORD_W-1:0] dn);
    gf2_result_t res;
    res = '0;
    case (op)
      sdgf2_pkg::OP_LOAD: begin
        if (idx < WORD_COUNT) begin
          sparse_mem[idx] = sp;
          dense_mem[idx]  = dn;
        end
      end
      sdgf2_pkg::OP_MUL: begin
        convolve_stores();
        res.done = 1'b1;
      end
      sdgf2_pkg::OP_READ: begin
        if (idx < WORD_COUNT) res.word = product_mem[idx];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [sdgf2_pkg::WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one input transaction, with an optional idle gap in front
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [sdgf2_pkg::OPC_W-1:0] op, int unsigned idx,
                           logic [sdgf2_pkg::WORD_W-1:0] sp,
                           logic [sdgf2_pkg::WORD_W-1:0] dn);
    int unsigned                 gap;
    logic [sdgf2_pkg::IDX_W-1:0] idx_w;
    idx_w = sdgf2_pkg::IDX_W'(idx);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(sdgf2_pkg::IN_TDATA_W - sdgf2_pkg::IDX_W - 2*sdgf2_pkg::WORD_W){1'b0}},
                      dn, sp, idx_w};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(gf2_step(op, idx_w, sp, dn));
  endtask

  // Sender stops and waits until every expected result is back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Checker: every output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    gf2_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_word %h done_res %b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata !== exp_res.word) begin
          $error("result_word mismatch: expected %h, actual %h", exp_res.word, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== exp_res.done) begin
          $error("done_res mismatch: expected %b, actual %b", exp_res.done, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stores come out of the clearing pass empty: zero reads and a zero product.
  task automatic test_reset_state();
    send_item(sdgf2_pkg::OP_READ, 0, '0, '0);
    send_item(sdgf2_pkg::OP_READ, WORD_COUNT - 1, '0, '0);
    send_item(sdgf2_pkg::OP_MUL, 0, '0, '0);
    send_item(sdgf2_pkg::OP_READ, 0, '0, '0);
  endtask

  // All-ones operands, including bits above the polynomial in the top word,
  // loads and reads past the store, and the unused opcode.
  task automatic test_operand_extremes();
    send_item(sdgf2_pkg::OP_LOAD, 0, '1, '1);
    send_item(sdgf2_pkg::OP_LOAD, WORD_COUNT - 1, '1, '1);
    send_item(sdgf2_pkg::OP_LOAD, IDX_MAX, '1, '1);
    send_item(sdgf2_pkg::OP_LOAD, WORD_COUNT, '1, '1);
    send_item(OP_NOP, IDX_MAX, '1, '1);
    send_item(sdgf2_pkg::OP_MUL, IDX_MAX, '1, '1);
    send_item(sdgf2_pkg::OP_READ, 0, '0, '0);
    send_item(sdgf2_pkg::OP_READ, 1, '0, '0);
    send_item(sdgf2_pkg::OP_READ, WORD_COUNT / 2, '0, '0);
    send_item(sdgf2_pkg::OP_READ, WORD_COUNT - 2, '0, '0);
    send_item(sdgf2_pkg::OP_READ, WORD_COUNT - 1, '0, '0);
    send_item(sdgf2_pkg::OP_READ, WORD_COUNT, '0, '0);
    send_item(sdgf2_pkg::OP_READ, IDX_MAX, '1, '1);
  endtask

  // Top live coefficient times itself wraps around the ring.
  task automatic test_wraparound();
    logic [sdgf2_pkg::WORD_W-1:0] top_bit;
    top_bit = 64'd1 << ((POLY_BITS - 1) % 64);
    send_item(sdgf2_pkg::OP_LOAD, 0, '0, '0);
    send_item(sdgf2_pkg::OP_LOAD, WORD_COUNT - 1, top_bit, top_bit);
    send_item(sdgf2_pkg::OP_MUL, 0, '0, '0);
    send_item(sdgf2_pkg::OP_READ, WORD_COUNT - 1, '0, '0);
    send_item(sdgf2_pkg::OP_READ, 0, '0, '0);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering back-to-back
  // transactions, so the output register fills and s_axis_tready drops.
  task automatic test_output_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (16) begin
      if ($urandom_range(0, 1) == 0) begin
        send_item(sdgf2_pkg::OP_READ, $urandom_range(0, WORD_COUNT - 1), '0, '0);
      end else begin
        send_item(sdgf2_pkg::OP_LOAD, $urandom_range(0, WORD_COUNT - 1), '0, rand_word());
      end
    end
    drain_results();
    gaps_on = 1'b1;
  endtask

  // Rounds of loads/reads/noise, then a weight-capped multiply and a batch
  // of product reads.
  task automatic test_random_rounds();
    int unsigned                  counted;
    int unsigned                  r;
    int unsigned                  n;
    int unsigned                  idx;
    logic [sdgf2_pkg::WORD_W-1:0] sp;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      n = $urandom_range(8, 24);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          // in-range load; sparse operand kept light except in the top word
          idx = ($urandom_range(0, 9) == 0) ? WORD_COUNT - 1
                                            : $urandom_range(0, WORD_COUNT - 1);
          r = $urandom_range(0, 99);
          if (idx == WORD_COUNT - 1 && r < 50) sp = rand_word();
          else if (r < 75)                     sp = '0;
          else                                 sp = 64'd1 << $urandom_range(0, 63);
          send_item(sdgf2_pkg::OP_LOAD, idx, sp, rand_word());
        end else if (r < 85) begin
          idx = ($urandom_range(0, 9) == 0) ? $urandom_range(WORD_COUNT, IDX_MAX)
                                            : $urandom_range(0, WORD_COUNT - 1);
          send_item(sdgf2_pkg::OP_READ, idx, rand_word(), rand_word());
        end else if (r < 93) begin
          send_item(OP_NOP, $urandom_range(0, IDX_MAX), rand_word(), rand_word());
        end else begin
          send_item(sdgf2_pkg::OP_LOAD, $urandom_range(WORD_COUNT, IDX_MAX), rand_word(),
                    rand_word());
        end
        counted++;
      end
      // Thin out the sparse operand so the multiply stays short.
      for (int w = 0; w < WORD_COUNT && sparse_live_weight() > WEIGHT_CAP; w++) begin
        if ((sparse_mem[w] & live_bits(w)) != '0) begin
          send_item(sdgf2_pkg::OP_LOAD, w, '0, rand_word());
          counted++;
        end
      end
      send_item(sdgf2_pkg::OP_MUL, $urandom_range(0, IDX_MAX), rand_word(), rand_word());
      counted++;
      n = $urandom_range(5, 15);
      repeat (n) begin
        send_item(sdgf2_pkg::OP_READ, $urandom_range(0, WORD_COUNT - 1), '0, '0);
        counted++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  initial begin
    clear_stores();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_operand_extremes();
    test_wraparound();
    test_output_backpressure();
    test_random_rounds();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
